// ===== sv/mfmt_pkg.sv =====
// Shared types and constants for the motor feedback multi-turn tracker.
// Used by mfmt_unwrap and motor_feedback_multiturn_tracker_top. No dependencies.
package mfmt_pkg;

  localparam int POS_BITS   = 16;
  localparam int TOTAL_BITS = 40;
  localparam int DELTA_BITS = 16;
  localparam int TCNT_BITS  = 24;

  localparam logic [7:0] WARMUP_RESET = 8'd50;
  localparam logic [7:0] COUNT_MAX    = 8'hFF;

  // one full turn spans 65535 codes; a jump of half a turn or more is a wrap
  localparam logic signed [17:0] FULL_TURN = 18'sd65535;
  localparam logic signed [17:0] HALF_JUMP = 18'sd32768;

  // Tracker state except the turn counter, whose width is a top-level parameter
  typedef struct packed {
    logic [7:0]            frame_counter;
    logic                  tracking;
    logic [POS_BITS-1:0]   last_position;
    logic [POS_BITS-1:0]   zero_offset;
    logic [TOTAL_BITS-1:0] total_hold;
  } track_st_t;

  typedef struct packed {
    logic [7:0]                   motor_id;
    logic [POS_BITS-1:0]          position_code;
    logic [11:0]                  speed_code;
    logic [11:0]                  current_code;
    logic                         tracking;
    logic signed [DELTA_BITS-1:0] delta_position;
    logic signed [TCNT_BITS-1:0]  turn_count;
    logic signed [TOTAL_BITS-1:0] total_position;
  } result_t;

endpackage

// ===== sv/mfmt_unwrap.sv =====
// Per-frame unwrap logic: field unpacking, warm-up count, wrap detection and
// total position. Purely combinational. Depends on mfmt_pkg.
module mfmt_unwrap #(
  parameter int TURN_BITS = 24
) (
  input  logic [47:0]             payload,
  input  logic [7:0]              warmup_frames,
  input  mfmt_pkg::track_st_t     st,
  input  logic [TURN_BITS-1:0]    turns,
  output mfmt_pkg::track_st_t     st_next,
  output logic [TURN_BITS-1:0]    turns_next,
  output mfmt_pkg::result_t       res
);
  import mfmt_pkg::*;

  logic [POS_BITS-1:0]          pos;
  logic [7:0]                   count_inc;
  logic                         trk;
  logic signed [17:0]           diff;
  logic signed [17:0]           delta_adj;
  logic [TURN_BITS-1:0]         turns_upd;
  logic signed [TOTAL_BITS-1:0] turns_ext;
  logic [TOTAL_BITS-1:0]        total;

  assign pos       = payload[39:24];
  assign count_inc = (st.frame_counter != COUNT_MAX) ? st.frame_counter + 8'd1
                                                     : st.frame_counter;
  assign trk       = st.tracking | (count_inc > warmup_frames);
  assign diff      = $signed({2'b00, pos}) - $signed({2'b00, st.last_position});

  always_comb begin
    delta_adj = diff;
    turns_upd = turns;
    if (diff >= HALF_JUMP) begin
      delta_adj = diff - FULL_TURN;
      turns_upd = turns - {{(TURN_BITS-1){1'b0}}, 1'b1};
    end else if (diff <= -HALF_JUMP) begin
      delta_adj = diff + FULL_TURN;
      turns_upd = turns + {{(TURN_BITS-1){1'b0}}, 1'b1};
    end
  end

  // turns * 65535 = (turns << 16) - turns
  assign turns_ext = TOTAL_BITS'($signed(turns_upd));
  assign total     = (turns_ext <<< POS_BITS) - turns_ext
                   + TOTAL_BITS'(pos) - TOTAL_BITS'(st.zero_offset);

  always_comb begin
    st_next.frame_counter = count_inc;
    st_next.tracking      = trk;
    st_next.last_position = pos;
    if (trk) begin
      st_next.zero_offset = st.zero_offset;
      st_next.total_hold  = total;
      turns_next          = turns_upd;
    end else begin
      st_next.zero_offset = pos;
      st_next.total_hold  = st.total_hold;
      turns_next          = turns;
    end
  end

  logic signed [TOTAL_BITS-1:0] turns_out;
  assign turns_out = TOTAL_BITS'($signed(turns_next));

  always_comb begin
    res.motor_id       = payload[47:40];
    res.position_code  = pos;
    res.speed_code     = payload[23:12];
    res.current_code   = payload[11:0];
    res.tracking       = trk;
    res.delta_position = trk ? delta_adj[DELTA_BITS-1:0] : '0;
    res.turn_count     = turns_out[TCNT_BITS-1:0];
    res.total_position = st_next.total_hold;
  end

endmodule

// ===== sv/motor_feedback_multiturn_tracker_top.sv =====
// Top level of the motor feedback multi-turn tracker: input register, state,
// output register and handshakes. Depends on mfmt_pkg and mfmt_unwrap.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one six-byte feedback frame per
//   transaction (byte 0 in bits 47:40, byte 5 in bits 7:0).
//   m_tvalid/m_tready/m_tdata/m_tuser return one result per frame.
//   cfg_valid/cfg_ready/cfg_data write the warm-up frame limit; cfg_ready is
//   always high. Write it only while no frame is in flight.
//   An accepted frame waits in the input register and is offered on m_* when it
//   moves into the result register. Throughput: one frame per cycle while m_tready
//   is high; the unwrap logic (two 18-bit compares, a turn step and one 40-bit
//   sum) runs between them, and tracker state updates as the result register loads.
//   Reset clears the frame counter, tracking flag, positions, turns and held
//   total, and sets the warm-up limit to 50; no results are pending after it.
//   When m_tready is low the result holds, one more frame is taken into the
//   input register, and s_tready then drops until the result is taken.
module motor_feedback_multiturn_tracker_top #(
  parameter int TURN_BITS = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // frame_payload[47:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  // motor_id[7:0], position_code[23:8], speed_code[35:24], current_code[47:36],
  // delta_position[63:48], turn_count[87:64], total_position[127:88]
  output logic [127:0] m_tdata,
  output logic         m_tuser,   // tracking
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data
);
  import mfmt_pkg::*;

  logic                 in_valid;
  logic [47:0]          in_data;
  logic                 advance;
  logic [7:0]           warmup_frames;
  track_st_t            st;
  track_st_t            st_next;
  logic [TURN_BITS-1:0] turns;
  logic [TURN_BITS-1:0] turns_next;
  result_t              res;
  result_t              out_res;

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_frames <= WARMUP_RESET;
    end else if (cfg_valid) begin
      warmup_frames <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
    end
  end

  mfmt_unwrap #(
    .TURN_BITS (TURN_BITS)
  ) u_unwrap (
    .payload       (in_data),
    .warmup_frames (warmup_frames),
    .st            (st),
    .turns         (turns),
    .st_next       (st_next),
    .turns_next    (turns_next),
    .res           (res)
  );

  // tracker state advances as the frame moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= '0;
      turns <= '0;
    end else if (advance) begin
      st    <= st_next;
      turns <= turns_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.total_position, out_res.turn_count, out_res.delta_position,
                    out_res.current_code, out_res.speed_code, out_res.position_code,
                    out_res.motor_id};
  assign m_tuser = out_res.tracking;

endmodule

// ===== sv/mfmt_checker.sv =====
// Port-level checks for motor_feedback_multiturn_tracker_top, attached by bind.
// Sees only the top-level ports; no package needed.
module mfmt_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic         m_tuser
);

  logic seen_tracking;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_tracking <= 1'b0;
    end else if (m_tvalid && m_tready && m_tuser) begin
      seen_tracking <= 1'b1;
    end
  end

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // tracking never drops once a tracked result went out
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && seen_tracking |-> m_tuser)
    else $error("tracking dropped");

  // warm-up results carry no delta
  a_warm_delta: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[63:48] == 16'h0000)
    else $error("nonzero delta during warm-up");

  // unwrapped delta stays within half a turn
  a_delta_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[63:48] != 16'h8000)
    else $error("delta out of range");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind motor_feedback_multiturn_tracker_top mfmt_checker u_mfmt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for motor_feedback_multiturn_tracker_top: feedback frames
// are checked against an in-bench multi-turn unwrap predictor. Depends on mfmt_pkg.
module testbench;
  import mfmt_pkg::*;

  localparam int  TURN_CODES     = 65535;
  localparam int  WRAP_JUMP      = 32768;
  localparam int  LATENCY_CYCLES = 4;
  localparam int  PHASE_FRAMES   = 225;
  localparam int  FILL_FRAMES    = 300;
  localparam real TIMEOUT_NS     = 3_000_000.0;

  typedef enum logic [1:0] {ROW_FRAME, ROW_CFG, ROW_FILL} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [47:0] arg;    // frame payload, warm-up limit or number of fill frames
    bit          typed;
    result_t     want;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic         m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_data = '0;

  // tracker shadow state
  logic [7:0]         warmup_limit;
  logic [7:0]         fb_count;
  logic               fb_tracking;
  logic [15:0]        last_pos;
  logic [15:0]        zero_ofs;
  logic signed [23:0] turn_ctr;
  logic [39:0]        held_total;

  result_t   pending_results[$];
  stim_row_t plan[$];
  int        err_count = 0;
  int        burst_left = 0;
  int        rx_cycle = 0;

  motor_feedback_multiturn_tracker_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("motor_feedback_multiturn_tracker_top test failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
    err_count++;
  endtask

  function automatic result_t unpacked_result(input logic [47:0] payload, input logic trk,
                                              input logic [15:0] delta,
                                              input logic [23:0] turns,
                                              input logic [39:0] total);
    result_t r;
    r.motor_id       = payload[47:40];
    r.position_code  = payload[39:24];
    r.speed_code     = payload[23:12];
    r.current_code   = payload[11:0];
    r.tracking       = trk;
    r.delta_position = delta;
    r.turn_count     = turns;
    r.total_position = total;
    return r;
  endfunction

  // Advance the shadow tracker by one frame and return the result it reports.
  function automatic result_t track_frame(input logic [47:0] payload);
    logic [15:0] pos;
    int          step;
    logic [39:0] turns_wide;
    pos  = payload[39:24];
    step = 0;
    if (fb_count != COUNT_MAX) fb_count++;
    if (fb_count > warmup_limit) fb_tracking = 1'b1;
    if (!fb_tracking) begin
      zero_ofs = pos;
      last_pos = pos;
    end else begin
      step = int'(pos) - int'(last_pos);
      if (step >= WRAP_JUMP) begin
        turn_ctr = turn_ctr - 24'sd1;
        step     = step - TURN_CODES;
      end else if (step <= -WRAP_JUMP) begin
        turn_ctr = turn_ctr + 24'sd1;
        step     = step + TURN_CODES;
      end
      last_pos   = pos;
      turns_wide = {{16{turn_ctr[23]}}, turn_ctr};
      held_total = turns_wide * 40'd65535 + 40'(pos) - 40'(zero_ofs);
    end
    return unpacked_result(payload, fb_tracking, step[15:0], turn_ctr, held_total);
  endfunction

  // Mostly a plausible trajectory around the last position, with boundary jumps,
  // zero crossings and some fully random frames mixed in.
  function automatic logic [47:0] random_payload();
    int          pick;
    int          jump;
    logic [15:0] pos;
    pick = $urandom_range(0, 99);
    jump = 0;
    if (pick < 20) return {16'($urandom()), 32'($urandom())};
    if (pick < 50) jump = $urandom_range(0, 400) - 200;
    else if (pick < 72) jump = $urandom_range(0, 65534) - 32767;
    else if (pick < 86) jump = ($urandom_range(0, 1) ? 32768 : -32768)
                               + $urandom_range(0, 2) - 1;
    if (pick >= 86) pos = $urandom_range(0, 1) ? 16'(16'hFFFF - $urandom_range(0, 3))
                                               : 16'($urandom_range(0, 3));
    else pos = last_pos + jump[15:0];
    return {8'($urandom()), pos, 24'($urandom())};
  endfunction

  task automatic send_frame(input logic [47:0] payload, input bit typed,
                            input result_t want);
    int gap;
    result_t got;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 20);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= payload;
    do @(posedge clk); while (!s_tready);
    got = track_frame(payload);
    pending_results.push_back(typed ? want : got);
  endtask

  // Drop valid, let every expected result drain, then give the pipe time to settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  task automatic write_warmup(input logic [7:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    warmup_limit = value;
  endtask

  // Result side: check each transaction, then stall on a rotating pattern.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, motor_id", 64'(m_tdata[7:0]), '0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[7:0] !== want.motor_id)
          report_mismatch("motor_id", 64'(m_tdata[7:0]), 64'(want.motor_id));
        if (m_tdata[23:8] !== want.position_code)
          report_mismatch("position_code", 64'(m_tdata[23:8]), 64'(want.position_code));
        if (m_tdata[35:24] !== want.speed_code)
          report_mismatch("speed_code", 64'(m_tdata[35:24]), 64'(want.speed_code));
        if (m_tdata[47:36] !== want.current_code)
          report_mismatch("current_code", 64'(m_tdata[47:36]), 64'(want.current_code));
        if (m_tuser !== want.tracking)
          report_mismatch("tracking", 64'(m_tuser), 64'(want.tracking));
        if (m_tdata[63:48] !== want.delta_position)
          report_mismatch("delta_position", 64'(m_tdata[63:48]),
                          64'(want.delta_position[15:0]));
        if (m_tdata[87:64] !== want.turn_count)
          report_mismatch("turn_count", 64'(m_tdata[87:64]), 64'(want.turn_count[23:0]));
        if (m_tdata[127:88] !== want.total_position)
          report_mismatch("total_position", 64'(m_tdata[127:88]),
                          64'(want.total_position[39:0]));
      end
    end
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 256) % 4)
      0: begin
        m_tready <= 1'b1;
      end
      1: begin
        m_tready <= (rx_cycle % 5) != 0;
      end
      2: begin
        m_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        m_tready <= (rx_cycle % 16) < 4;
      end
    endcase
  end

  initial begin
    logic [7:0] phase_limits[6];
    result_t    none;
    none = '0;
    phase_limits = '{8'd0, 8'd254, 8'd1, WARMUP_RESET, 8'd255, 8'($urandom_range(2, 253))};

    warmup_limit = WARMUP_RESET;
    fb_count     = '0;
    fb_tracking  = 1'b0;
    last_pos     = '0;
    zero_ofs     = '0;
    turn_ctr     = '0;
    held_total   = '0;

    // warm-up frames under the reset limit: fields unpack, nothing tracks
    plan.push_back('{ROW_FRAME, 48'h0, 1'b1,
                     unpacked_result(48'h0, 1'b0, '0, '0, '0)});
    plan.push_back('{ROW_FRAME, 48'hFFFF_FFFF_FFFF, 1'b1,
                     unpacked_result(48'hFFFF_FFFF_FFFF, 1'b0, '0, '0, '0)});
    plan.push_back('{ROW_FRAME, 48'h5AA5_5AA5_5AA5, 1'b1,
                     unpacked_result(48'h5AA5_5AA5_5AA5, 1'b0, '0, '0, '0)});
    // a limit of 255 is never exceeded: the saturated counter keeps warming up
    plan.push_back('{ROW_CFG, 48'd255, 1'b0, none});
    plan.push_back('{ROW_FILL, 48'(FILL_FRAMES), 1'b0, none});
    // saturated counter exceeds 254: the next frame starts tracking
    plan.push_back('{ROW_CFG, 48'd254, 1'b0, none});
    plan.push_back('{ROW_FRAME, {8'h01, 16'h0000, 12'h800, 12'h800}, 1'b0, none});
    plan.push_back('{ROW_FRAME, {8'h02, 16'h8000, 12'hFFF, 12'h000}, 1'b0, none});
    plan.push_back('{ROW_FRAME, {8'h03, 16'h0000, 12'h000, 12'hFFF}, 1'b0, none});
    plan.push_back('{ROW_FRAME, {8'h04, 16'h7FFF, 12'h801, 12'h7FF}, 1'b0, none});
    plan.push_back('{ROW_FRAME, {8'h05, 16'h0000, 12'h7FF, 12'h801}, 1'b0, none});
    plan.push_back('{ROW_FRAME, {8'h06, 16'hFFFF, 12'h123, 12'h456}, 1'b0, none});
    plan.push_back('{ROW_FRAME, {8'h07, 16'h0000, 12'hABC, 12'hDEF}, 1'b0, none});
    plan.push_back('{ROW_FRAME, {8'h08, 16'hFFFF, 12'h555, 12'hAAA}, 1'b0, none});
    plan.push_back('{ROW_FRAME, {8'h09, 16'h7FFF, 12'hAAA, 12'h555}, 1'b0, none});
    plan.push_back('{ROW_FRAME, {8'hFE, 16'hFFFE, 12'h001, 12'hFFE}, 1'b0, none});
    // tracking is sticky across limit changes
    plan.push_back('{ROW_CFG, 48'd0, 1'b0, none});
    plan.push_back('{ROW_FRAME, {8'h80, 16'h1234, 12'h800, 12'h800}, 1'b0, none});
    plan.push_back('{ROW_CFG, 48'd255, 1'b0, none});
    plan.push_back('{ROW_FRAME, {8'h7F, 16'h9234, 12'h7FF, 12'h7FF}, 1'b0, none});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_FRAME: begin
          send_frame(plan[i].arg, plan[i].typed, plan[i].want);
        end
        ROW_CFG: begin
          write_warmup(plan[i].arg[7:0]);
        end
        default: begin
          repeat (int'(plan[i].arg)) send_frame(random_payload(), 1'b0, none);
        end
      endcase
    end

    foreach (phase_limits[p]) begin
      write_warmup(phase_limits[p]);
      repeat (PHASE_FRAMES) send_frame(random_payload(), 1'b0, none);
    end

    wait_idle();
    if (err_count == 0) begin
      $display("motor_feedback_multiturn_tracker_top test passed");
    end else begin
      $display("motor_feedback_multiturn_tracker_top test failed");
    end
    $finish;
  end

endmodule
